// ===== design/geometry_command_vertex_decoder_macros.svh =====
// assertion macros for the geometry command vertex decoder
// used by geometry_command_vertex_decoder.sv, no other dependencies
`ifndef GEOMETRY_COMMAND_VERTEX_DECODER_MACROS_SVH
`define GEOMETRY_COMMAND_VERTEX_DECODER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define GCVD_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define GCVD_ASSERT_AFTER(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gcvd_pkg.sv =====
// shared types, command codes and helper functions for the geometry command decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gcvd_pkg;

    // command bytes
    localparam logic [7:0] CMD_MATRIX   = 8'h14;
    localparam logic [7:0] CMD_SKIP3    = 8'h1b;
    localparam logic [7:0] CMD_COLOR    = 8'h20;
    localparam logic [7:0] CMD_NORMAL   = 8'h21;
    localparam logic [7:0] CMD_TEXCOORD = 8'h22;
    localparam logic [7:0] CMD_VTX16    = 8'h23;
    localparam logic [7:0] CMD_VTX10    = 8'h24;
    localparam logic [7:0] CMD_VTX_XY   = 8'h25;
    localparam logic [7:0] CMD_VTX_XZ   = 8'h26;
    localparam logic [7:0] CMD_VTX_YZ   = 8'h27;
    localparam logic [7:0] CMD_VTX_DIFF = 8'h28;
    localparam logic [7:0] CMD_SKIP1    = 8'h30;
    localparam logic [7:0] CMD_BEGIN    = 8'h40;
    localparam logic [7:0] CMD_END      = 8'h41;

    // primitive types
    localparam logic [2:0] PRIM_QUADS = 3'd1;
    localparam logic [2:0] PRIM_NONE  = 3'd4;

    // command slot value when no packed word is pending
    localparam logic [2:0] SLOT_IDLE = 3'd4;

    localparam int TDATA_OUT_W = 144;

    typedef enum logic [1:0] {
        VTX_NONE,
        VTX_ONE,
        VTX_QUAD
    } vtx_mode_t;

    // first member sits in the high bits, so pos_x ends up lowest
    typedef struct packed {
        logic [4:0]  matrix_id;
        logic [15:0] tex_t;
        logic [15:0] tex_s;
        logic [23:0] color_rgb;
        logic [29:0] normal_packed;
        logic [15:0] pos_z;
        logic [15:0] pos_y;
        logic [15:0] pos_x;
    } vertex_t;

    function automatic logic [1:0] param_count(input logic [7:0] cmd);
        logic [1:0] n;
        unique case (cmd) inside
            CMD_VTX16: n = 2'd2;
            CMD_SKIP3: n = 2'd3;
            CMD_BEGIN, CMD_VTX10, CMD_VTX_XY, CMD_VTX_XZ, CMD_VTX_YZ, CMD_VTX_DIFF,
            CMD_NORMAL, CMD_COLOR, CMD_TEXCOORD, CMD_MATRIX, CMD_SKIP1: n = 2'd1;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

    // 5-bit channel to 8 bits by replicating the top bits
    function automatic logic [7:0] exp5(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

    function automatic logic [15:0] sext10(input logic [9:0] v);
        return {{6{v[9]}}, v};
    endfunction

endpackage

`default_nettype wire

// ===== design/geometry_command_vertex_decoder.sv =====
// geometry command vertex decoder: packed command words in, vertices and markers out
// depends on gcvd_pkg and geometry_command_vertex_decoder_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "geometry_command_vertex_decoder_macros.svh"

// Decodes a stream of 32-bit geometry command words. An idle word holds four
// command bytes, run low byte first; each command then takes its parameter
// words from the following transfers. The decoder keeps the current position
// (4.12), normal, expanded colour, texcoord, matrix id and primitive type, and
// sends a vertex for every position command, or six triangle vertices (0,1,2,
// 0,2,3) for each completed group of four in quads mode; end-of-primitive sends
// a marker. A word whose results are known is decoded in the cycle it is taken:
// state is updated at the transfer and the results are queued as a short
// descriptor (vertex mode plus count). The single output register then issues
// one result per cycle while m_tready allows, vertices read from the current
// attributes or from the four-entry quad store. Throughput: one word per cycle
// while each word yields at most one result and the output is not stalled; a word
// yielding several results (up to nine) stalls the input until its last queued
// result moves into the output register; the next word is taken in that cycle.
module geometry_command_vertex_decoder (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,  // word[31:0]
    input  wire logic         s_tuser,  // mesh_start
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pos_x[15:0], pos_y[31:16], pos_z[47:32], normal_packed[77:48],
    // color_rgb[101:78], tex_s[117:102], tex_t[133:118], matrix_id[138:134],
    // prim_type[141:139], zero pad[143:142]
    output logic [gcvd_pkg::TDATA_OUT_W-1:0] m_tdata,
    output logic              m_tuser,  // kind: 0 vertex, 1 end-of-primitive marker
    output logic              m_tlast   // last result caused by one input word
);

    // decoder state
    logic [31:0]         pend_reg, pend_next;
    logic [2:0]          slot_reg, slot_next;
    logic [1:0]          params_reg, params_next;
    logic [31:0]         first_reg, first_next;
    gcvd_pkg::vertex_t   cur_vtx_reg, cur_vtx_next;
    logic [2:0]          cur_prim_reg, cur_prim_next;
    logic [1:0]          quad_cnt_reg, quad_cnt_next;

    // state as seen by this word (mesh_start forces the reset values)
    logic [2:0]          eff_slot;
    logic [1:0]          eff_params;
    logic [31:0]         eff_first;
    gcvd_pkg::vertex_t   eff_vtx;
    logic [2:0]          eff_prim;
    logic [1:0]          eff_qc;

    logic                exec_en;
    logic                run_en;
    logic [2:0]          run_start;
    logic                run_found;
    logic [7:0]          cur_cmd;
    logic                vtx_push;
    logic [2:0]          marker_cnt;
    gcvd_pkg::vtx_mode_t vtx_mode_next;
    logic [3:0]          vtx_cnt;
    logic [3:0]          res_total;
    logic [1:0]          slot_pc [4];
    logic                slot_end [4];

    // quad store
    gcvd_pkg::vertex_t   quad_mem [4];
    logic                q_wr_en;
    logic [1:0]          q_wr_addr;
    logic [1:0]          q_rd_addr;

    // result queue descriptor
    logic [3:0]          pend_cnt_reg;
    logic [3:0]          pend_idx_reg;
    gcvd_pkg::vtx_mode_t pend_mode_reg;

    // output register
    logic                out_valid_reg;
    gcvd_pkg::vertex_t   out_vtx_reg;
    logic [2:0]          out_prim_reg;
    logic                out_kind_reg;
    logic                out_last_reg;

    logic                accept;
    logic                out_load;
    logic                gen;
    logic                is_vtx;

    assign out_load = !out_valid_reg || m_tready;
    assign gen      = (pend_cnt_reg != 4'd0);
    // take a word once the queue is empty or its last entry leaves this cycle
    assign s_tready = (pend_cnt_reg == 4'd0) || ((pend_cnt_reg == 4'd1) && out_load);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_prim_reg, out_vtx_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // per-slot decode of the packed word that will be pending
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            slot_pc[j]  = gcvd_pkg::param_count(pend_next[8*j +: 8]);
            slot_end[j] = (pend_next[8*j +: 8] == gcvd_pkg::CMD_END);
        end
    end

    // next state for one accepted word
    always_comb
    begin
        eff_slot   = s_tuser ? gcvd_pkg::SLOT_IDLE : slot_reg;
        eff_params = s_tuser ? 2'd0 : params_reg;
        eff_first  = s_tuser ? 32'd0 : first_reg;
        eff_vtx    = s_tuser ? '0 : cur_vtx_reg;
        eff_prim   = s_tuser ? gcvd_pkg::PRIM_NONE : cur_prim_reg;
        eff_qc     = s_tuser ? 2'd0 : quad_cnt_reg;

        pend_next     = (eff_slot == gcvd_pkg::SLOT_IDLE) ? s_tdata : pend_reg;
        slot_next     = eff_slot;
        params_next   = eff_params;
        first_next    = eff_first;
        cur_vtx_next  = eff_vtx;
        cur_prim_next = eff_prim;
        quad_cnt_next = eff_qc;
        exec_en       = 1'b0;
        run_en        = 1'b0;
        run_start     = 3'd0;
        run_found     = 1'b0;
        vtx_push      = 1'b0;
        marker_cnt    = 3'd0;
        vtx_mode_next = gcvd_pkg::VTX_NONE;
        q_wr_en       = 1'b0;
        q_wr_addr     = eff_qc;
        cur_cmd       = pend_reg[{eff_slot[1:0], 3'b000} +: 8];

        if (eff_slot == gcvd_pkg::SLOT_IDLE)
        begin
            run_en    = 1'b1;
            run_start = 3'd0;
        end
        else if (eff_params > 2'd1)
        begin
            // parameter word of a multi-word command, not yet the last one
            if (eff_params == 2'd2)
            begin
                first_next = s_tdata;
            end
            params_next = eff_params - 2'd1;
        end
        else
        begin
            exec_en   = 1'b1;
            run_en    = 1'b1;
            run_start = eff_slot + 3'd1;
        end

        if (exec_en)
        begin
            unique case (cur_cmd)
                gcvd_pkg::CMD_BEGIN:
                begin
                    cur_prim_next = {1'b0, s_tdata[1:0]};
                    quad_cnt_next = 2'd0;
                end
                gcvd_pkg::CMD_VTX16:
                begin
                    cur_vtx_next.pos_x = eff_first[15:0];
                    cur_vtx_next.pos_y = eff_first[31:16];
                    cur_vtx_next.pos_z = s_tdata[15:0];
                    vtx_push           = 1'b1;
                end
                gcvd_pkg::CMD_VTX10:
                begin
                    // 4.6 values moved up to 4.12
                    cur_vtx_next.pos_x = {s_tdata[9:0], 6'd0};
                    cur_vtx_next.pos_y = {s_tdata[19:10], 6'd0};
                    cur_vtx_next.pos_z = {s_tdata[29:20], 6'd0};
                    vtx_push           = 1'b1;
                end
                gcvd_pkg::CMD_VTX_XY:
                begin
                    cur_vtx_next.pos_x = s_tdata[15:0];
                    cur_vtx_next.pos_y = s_tdata[31:16];
                    vtx_push           = 1'b1;
                end
                gcvd_pkg::CMD_VTX_XZ:
                begin
                    cur_vtx_next.pos_x = s_tdata[15:0];
                    cur_vtx_next.pos_z = s_tdata[31:16];
                    vtx_push           = 1'b1;
                end
                gcvd_pkg::CMD_VTX_YZ:
                begin
                    cur_vtx_next.pos_y = s_tdata[15:0];
                    cur_vtx_next.pos_z = s_tdata[31:16];
                    vtx_push           = 1'b1;
                end
                gcvd_pkg::CMD_VTX_DIFF:
                begin
                    // wrapping 16-bit sums
                    cur_vtx_next.pos_x = eff_vtx.pos_x + gcvd_pkg::sext10(s_tdata[9:0]);
                    cur_vtx_next.pos_y = eff_vtx.pos_y + gcvd_pkg::sext10(s_tdata[19:10]);
                    cur_vtx_next.pos_z = eff_vtx.pos_z + gcvd_pkg::sext10(s_tdata[29:20]);
                    vtx_push           = 1'b1;
                end
                gcvd_pkg::CMD_NORMAL:
                begin
                    cur_vtx_next.normal_packed = s_tdata[29:0];
                end
                gcvd_pkg::CMD_COLOR:
                begin
                    cur_vtx_next.color_rgb = {gcvd_pkg::exp5(s_tdata[14:10]),
                                              gcvd_pkg::exp5(s_tdata[9:5]),
                                              gcvd_pkg::exp5(s_tdata[4:0])};
                end
                gcvd_pkg::CMD_TEXCOORD:
                begin
                    cur_vtx_next.tex_s = s_tdata[15:0];
                    cur_vtx_next.tex_t = s_tdata[31:16];
                end
                gcvd_pkg::CMD_MATRIX:
                begin
                    cur_vtx_next.matrix_id = s_tdata[4:0];
                end
                default:
                begin
                end
            endcase
        end

        if (vtx_push)
        begin
            if (eff_prim == gcvd_pkg::PRIM_QUADS)
            begin
                q_wr_en       = 1'b1;
                quad_cnt_next = eff_qc + 2'd1;
                if (eff_qc == 2'd3)
                begin
                    vtx_mode_next = gcvd_pkg::VTX_QUAD;
                end
            end
            else
            begin
                vtx_mode_next = gcvd_pkg::VTX_ONE;
            end
        end

        // run parameterless commands until one needs parameters
        if (run_en)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if (!run_found && (3'(j) >= run_start))
                begin
                    if (slot_pc[j] != 2'd0)
                    begin
                        run_found   = 1'b1;
                        slot_next   = 3'(j);
                        params_next = slot_pc[j];
                    end
                    else if (slot_end[j])
                    begin
                        marker_cnt = marker_cnt + 3'd1;
                    end
                end
            end
            if (!run_found)
            begin
                slot_next   = gcvd_pkg::SLOT_IDLE;
                params_next = 2'd0;
            end
        end

        // end-of-primitive drops an incomplete quad group
        if (marker_cnt != 3'd0)
        begin
            quad_cnt_next = 2'd0;
        end
    end

    always_comb
    begin
        case (vtx_mode_next)
            gcvd_pkg::VTX_ONE:  vtx_cnt = 4'd1;
            gcvd_pkg::VTX_QUAD: vtx_cnt = 4'd6;
            default:            vtx_cnt = 4'd0;
        endcase
        res_total = vtx_cnt + {1'b0, marker_cnt};
    end

    // which result the queue issues next
    always_comb
    begin
        is_vtx = ((pend_mode_reg == gcvd_pkg::VTX_ONE) && (pend_idx_reg == 4'd0))
              || ((pend_mode_reg == gcvd_pkg::VTX_QUAD) && (pend_idx_reg < 4'd6));
        // triangle order 0,1,2,0,2,3
        case (pend_idx_reg[2:0])
            3'd1:    q_rd_addr = 2'd1;
            3'd2:    q_rd_addr = 2'd2;
            3'd4:    q_rd_addr = 2'd2;
            3'd5:    q_rd_addr = 2'd3;
            default: q_rd_addr = 2'd0;
        endcase
    end

    // control and decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 32'd0;
            slot_reg      <= gcvd_pkg::SLOT_IDLE;
            params_reg    <= 2'd0;
            first_reg     <= 32'd0;
            cur_vtx_reg   <= '0;
            cur_prim_reg  <= gcvd_pkg::PRIM_NONE;
            quad_cnt_reg  <= 2'd0;
            pend_cnt_reg  <= 4'd0;
            pend_idx_reg  <= 4'd0;
            pend_mode_reg <= gcvd_pkg::VTX_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= gen;
            end
            if (accept)
            begin
                pend_reg      <= pend_next;
                slot_reg      <= slot_next;
                params_reg    <= params_next;
                first_reg     <= first_next;
                cur_vtx_reg   <= cur_vtx_next;
                cur_prim_reg  <= cur_prim_next;
                quad_cnt_reg  <= quad_cnt_next;
                pend_cnt_reg  <= res_total;
                pend_idx_reg  <= 4'd0;
                pend_mode_reg <= vtx_mode_next;
            end
            else if (out_load && gen)
            begin
                pend_cnt_reg <= pend_cnt_reg - 4'd1;
                pend_idx_reg <= pend_idx_reg + 4'd1;
            end
        end
    end

    // quad store write
    always_ff @(posedge clk)
    begin
        if (accept && q_wr_en)
        begin
            quad_mem[q_wr_addr] <= cur_vtx_next;
        end
    end

    // output payload, quad store read lands here
    always_ff @(posedge clk)
    begin
        if (out_load && gen)
        begin
            out_kind_reg <= !is_vtx;
            out_last_reg <= (pend_cnt_reg == 4'd1);
            out_prim_reg <= cur_prim_reg;
            if (!is_vtx)
            begin
                out_vtx_reg <= '0;
            end
            else if (pend_mode_reg == gcvd_pkg::VTX_QUAD)
            begin
                out_vtx_reg <= quad_mem[q_rd_addr];
            end
            else
            begin
                out_vtx_reg <= cur_vtx_reg;
            end
        end
    end

    `GCVD_ASSERT_HOLDS(a_slot_params, clk, rst_n, 1'b1,
        ((slot_reg == gcvd_pkg::SLOT_IDLE) == (params_reg == 2'd0)),
        "command slot and parameter count disagree")
    `GCVD_ASSERT_HOLDS(a_busy_stall, clk, rst_n, (pend_cnt_reg > 4'd1), !s_tready,
        "input taken while several results are still queued")
    `GCVD_ASSERT_AFTER(a_quad_wrap, clk, rst_n,
        (accept && (vtx_mode_next == gcvd_pkg::VTX_QUAD)), (quad_cnt_reg == 2'd0),
        "quad group count did not wrap after a full group")
    `GCVD_ASSERT_AFTER(a_mesh_prim, clk, rst_n, (accept && s_tuser),
        (cur_prim_reg == gcvd_pkg::PRIM_NONE), "mesh start left a primitive type")
    `GCVD_ASSERT_AFTER(a_last_out, clk, rst_n, (out_load && (pend_cnt_reg == 4'd1)),
        (m_tvalid && m_tlast), "final queued result not marked last")

endmodule

`default_nettype wire

// ===== test/geometry_command_vertex_decoder_tb.sv =====
// self-checking testbench for geometry_command_vertex_decoder
// predicts vertices and markers for each accepted command word and checks them in order
// depends on gcvd_pkg and the decoder rtl only
`timescale 1ns / 1ps

module geometry_command_vertex_decoder_tb;

    import gcvd_pkg::*;

    // one word queued for the input stream
    typedef struct packed {
        logic [31:0] word;
        logic        mesh_start;
        logic        drain;      // hold this word back until all results are in
    } stream_word_t;

    // attributes that travel with one vertex
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [29:0] nrm;
        logic [23:0] rgb;
        logic [31:0] tex;        // s 15:0, t 31:16
        logic [4:0]  mtx;
    } corner_t;

    // one expected transfer on the result stream
    typedef struct packed {
        logic        kind;
        corner_t     c;
        logic [2:0]  prim;
        logic        last;
    } decoded_result_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SKIP5,
        RX_SPARSE
    } rx_pattern_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    geometry_command_vertex_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // word
        .s_tuser  (s_tuser),   // mesh_start
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // pos_x, pos_y, pos_z, normal, color, tex_s, tex_t, matrix, prim
        .m_tuser  (m_tuser),   // kind
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // decoder state as seen by the predictor
    // ------------------------------------------------------------------
    logic [31:0] cmd_word;
    logic [2:0]  cmd_slot;
    logic [1:0]  words_owed;
    logic [31:0] held_param;     // first of two vtx16 parameters
    logic [15:0] px, py, pz;
    logic [29:0] nrm;
    logic [23:0] rgb;
    logic [31:0] tex;
    logic [4:0]  mtx;
    logic [2:0]  prim;
    corner_t     quad_store [4];
    logic [1:0]  quad_fill;

    decoded_result_t step_out [$];          // results of the word being decoded
    decoded_result_t pending_results [$];   // expected, not yet seen on the bus
    stream_word_t    word_q [$];            // stimulus not yet transferred

    int words_taken = 0;
    int quads_done = 0;
    int vertices_seen = 0;
    int markers_seen = 0;
    int mismatches = 0;
    bit drain_next = 1'b0;
    bit in_sync = 1'b0;

    function automatic int operand_words(input logic [7:0] cmd);
        case (cmd)
            CMD_VTX16: return 2;
            CMD_SKIP3: return 3;
            CMD_BEGIN, CMD_VTX10, CMD_VTX_XY, CMD_VTX_XZ, CMD_VTX_YZ, CMD_VTX_DIFF,
            CMD_NORMAL, CMD_COLOR, CMD_TEXCOORD, CMD_MATRIX, CMD_SKIP1: return 1;
            default: return 0;
        endcase
    endfunction

    // 5-bit channel widened to 8 bits
    function automatic logic [7:0] widen5(input logic [4:0] c);
        logic [7:0] v;
        v = {3'd0, c};
        return (v << 3) | (v >> 2);
    endfunction

    // signed 10-bit delta as a 16-bit step
    function automatic logic [15:0] delta10(input logic [9:0] d);
        return {{6{d[9]}}, d};
    endfunction

    task automatic clear_context();
        cmd_word = '0;
        cmd_slot = SLOT_IDLE;
        words_owed = '0;
        held_param = '0;
        px = '0;
        py = '0;
        pz = '0;
        nrm = '0;
        rgb = '0;
        tex = '0;
        mtx = '0;
        prim = PRIM_NONE;
        quad_fill = '0;
    endtask

    task automatic emit(input logic kind, input corner_t c);
        decoded_result_t r;
        r.kind = kind;
        r.c = c;
        r.prim = prim;
        r.last = 1'b0;
        step_out.insert(step_out.size(), r);
    endtask

    // a position command: one vertex, or a whole quad as two triangles
    task automatic place_vertex();
        corner_t c;
        c = '{x: px, y: py, z: pz, nrm: nrm, rgb: rgb, tex: tex, mtx: mtx};
        if (prim != PRIM_QUADS)
        begin
            emit(1'b0, c);
        end
        else
        begin
            quad_store[quad_fill] = c;
            quad_fill = quad_fill + 2'd1;
            if (quad_fill == 2'd0)
            begin
                quads_done++;
                emit(1'b0, quad_store[0]);
                emit(1'b0, quad_store[1]);
                emit(1'b0, quad_store[2]);
                emit(1'b0, quad_store[0]);
                emit(1'b0, quad_store[2]);
                emit(1'b0, quad_store[3]);
            end
        end
    endtask

    task automatic execute(input logic [7:0] cmd, input logic [31:0] a);
        case (cmd)
            CMD_BEGIN:
            begin
                prim = {1'b0, a[1:0]};
                quad_fill = '0;
            end
            CMD_END:
            begin
                // open quad group is dropped, marker carries only the prim type
                quad_fill = '0;
                emit(1'b1, '0);
            end
            CMD_VTX16:
            begin
                px = held_param[15:0];
                py = held_param[31:16];
                pz = a[15:0];
                place_vertex();
            end
            CMD_VTX10:
            begin
                // 4.6 values moved up to 4.12
                px = {a[9:0], 6'd0};
                py = {a[19:10], 6'd0};
                pz = {a[29:20], 6'd0};
                place_vertex();
            end
            CMD_VTX_XY:
            begin
                px = a[15:0];
                py = a[31:16];
                place_vertex();
            end
            CMD_VTX_XZ:
            begin
                px = a[15:0];
                pz = a[31:16];
                place_vertex();
            end
            CMD_VTX_YZ:
            begin
                py = a[15:0];
                pz = a[31:16];
                place_vertex();
            end
            CMD_VTX_DIFF:
            begin
                // sums wrap at 16 bits
                px = px + delta10(a[9:0]);
                py = py + delta10(a[19:10]);
                pz = pz + delta10(a[29:20]);
                place_vertex();
            end
            CMD_NORMAL:   nrm = a[29:0];
            CMD_COLOR:    rgb = {widen5(a[14:10]), widen5(a[9:5]), widen5(a[4:0])};
            CMD_TEXCOORD: tex = a;
            CMD_MATRIX:   mtx = a[4:0];
            default: ;
        endcase
    endtask

    // run parameterless commands until one needs words or the packed word is used up
    task automatic run_slots();
        logic [7:0] c;
        int n;
        while (cmd_slot < SLOT_IDLE)
        begin
            c = cmd_word[8*cmd_slot +: 8];
            n = operand_words(c);
            if (n != 0)
            begin
                words_owed = n[1:0];
                return;
            end
            execute(c, '0);
            cmd_slot = cmd_slot + 3'd1;
        end
        cmd_slot = SLOT_IDLE;
        words_owed = '0;
    endtask

    // predict the results of one accepted word and queue them
    task automatic decode_word(input logic [31:0] w, input logic ms);
        logic [7:0] c;
        step_out.delete();
        if (ms)
            clear_context();
        if (cmd_slot >= SLOT_IDLE)
        begin
            cmd_word = w;
            cmd_slot = '0;
            run_slots();
        end
        else
        begin
            c = cmd_word[8*cmd_slot +: 8];
            if (words_owed > 2'd1)
            begin
                if (words_owed == 2'd2)
                    held_param = w;
                words_owed = words_owed - 2'd1;
            end
            else
            begin
                words_owed = '0;
                execute(c, w);
                cmd_slot = cmd_slot + 3'd1;
                run_slots();
            end
        end
        if (step_out.size() != 0)
            step_out[step_out.size()-1].last = 1'b1;
        foreach (step_out[i])
            pending_results.insert(pending_results.size(), step_out[i]);
    endtask

    // ------------------------------------------------------------------
    // stimulus construction
    // ------------------------------------------------------------------
    task automatic queue_word(input logic [31:0] w, input logic ms);
        stream_word_t s;
        s.word = w;
        s.mesh_start = ms;
        s.drain = drain_next;
        drain_next = 1'b0;
        word_q.insert(word_q.size(), s);
    endtask

    function automatic logic [7:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return CMD_BEGIN;
        if (r < 17) return CMD_END;
        if (r < 25) return CMD_VTX16;
        if (r < 31) return CMD_VTX10;
        if (r < 37) return CMD_VTX_XY;
        if (r < 42) return CMD_VTX_XZ;
        if (r < 47) return CMD_VTX_YZ;
        if (r < 55) return CMD_VTX_DIFF;
        if (r < 60) return CMD_NORMAL;
        if (r < 65) return CMD_COLOR;
        if (r < 70) return CMD_TEXCOORD;
        if (r < 75) return CMD_MATRIX;
        if (r < 79) return CMD_SKIP3;
        if (r < 83) return CMD_SKIP1;
        return 8'($urandom_range(0, 255));   // mostly unknown bytes
    endfunction

    // a run of well-formed command words with their parameters, random content
    task automatic add_mesh();
        int n_words;
        logic [7:0] b [4];
        logic [31:0] w;
        bit cut;
        n_words = $urandom_range(1, 10);
        cut = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < n_words; k++)
        begin
            for (int i = 0; i < 4; i++)
                b[i] = pick_cmd();
            if (k == 0 && $urandom_range(0, 1) == 1)
                b[0] = CMD_BEGIN;
            queue_word({b[3], b[2], b[1], b[0]},
                       (k == 0) && (!in_sync || $urandom_range(0, 2) == 0));
            in_sync = 1'b1;
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < operand_words(b[i]); j++)
                begin
                    // broken sequence: stop mid-parameters, next mesh restarts
                    if (cut && $urandom_range(0, 7) == 0)
                    begin
                        in_sync = 1'b0;
                        return;
                    end
                    w = $urandom;
                    // quads more often than the other types
                    if (b[i] == CMD_BEGIN && $urandom_range(0, 1) == 1)
                        w[1:0] = PRIM_QUADS[1:0];
                    queue_word(w, 1'b0);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of transfers with random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin : driver
        bit hold;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
        end
        else
        begin
            hold = s_tvalid && !s_tready;
            if (s_tvalid && s_tready)
            begin
                decode_word(word_q[0].word, word_q[0].mesh_start);
                void'(word_q.pop_front());
                words_taken++;
            end
            if (hold)
            begin
                // word stays on the bus until taken
            end
            else if (gap_left != 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (word_q.size() != 0 && !(word_q[0].drain && pending_results.size() != 0))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= word_q[0].word;
                s_tuser <= word_q[0].mesh_start;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: check each result transfer, stall on a changing pattern
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    rx_pattern_t rx_pattern = RX_OPEN;
    int rx_left = 0;
    int rx_cycle = 0;

    always @(posedge clk or negedge rst_n)
    begin : monitor
        decoded_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with nothing expected (kind %0b)", m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (want.kind)
                        markers_seen++;
                    else
                        vertices_seen++;
                    check_field("kind", 32'(want.kind), 32'(m_tuser));
                    check_field("last", 32'(want.last), 32'(m_tlast));
                    check_field("pos_x", 32'(want.c.x), 32'(m_tdata[15:0]));
                    check_field("pos_y", 32'(want.c.y), 32'(m_tdata[31:16]));
                    check_field("pos_z", 32'(want.c.z), 32'(m_tdata[47:32]));
                    check_field("normal_packed", 32'(want.c.nrm), 32'(m_tdata[77:48]));
                    check_field("color_rgb", 32'(want.c.rgb), 32'(m_tdata[101:78]));
                    check_field("tex_s", 32'(want.c.tex[15:0]), 32'(m_tdata[117:102]));
                    check_field("tex_t", 32'(want.c.tex[31:16]), 32'(m_tdata[133:118]));
                    check_field("matrix_id", 32'(want.c.mtx), 32'(m_tdata[138:134]));
                    check_field("prim_type", 32'(want.prim), 32'(m_tdata[141:139]));
                end
            end
            // pick a new stall pattern now and then
            if (rx_left == 0)
            begin
                rx_pattern = rx_pattern_t'($urandom_range(0, 3));
                rx_left = $urandom_range(32, 200);
            end
            else
            begin
                rx_left--;
            end
            rx_cycle++;
            case (rx_pattern)
                RX_OPEN:  m_tready <= 1'b1;
                RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
                RX_SKIP5: m_tready <= (rx_cycle % 5) != 0;
                default:  m_tready <= (rx_cycle % 8) == 0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin : main
        int directed;
        clear_context();

        // attributes at their extremes, set on a fresh mesh
        queue_word({CMD_MATRIX, CMD_TEXCOORD, CMD_NORMAL, CMD_COLOR}, 1'b1);
        queue_word(32'h0000_7FFF, 1'b0);      // white
        queue_word(32'h2008_0200, 1'b0);      // normal all -512
        queue_word(32'h8000_7FFF, 1'b0);      // s max, t min
        queue_word(32'hFFFF_FFFF, 1'b0);      // matrix 31
        // vertex before any begin, marker and unknown bytes in the same word
        queue_word({8'hFF, 8'h00, CMD_END, CMD_VTX16}, 1'b0);
        queue_word(32'h8000_7FFF, 1'b0);
        queue_word(32'hFFFF_8000, 1'b0);
        // quads: three corners, then the fourth completes the group
        queue_word({CMD_VTX_XZ, CMD_VTX_XY, CMD_VTX10, CMD_BEGIN}, 1'b0);
        queue_word(32'hFFFF_FFFD, 1'b0);
        queue_word(32'h2008_01FF, 1'b0);
        queue_word(32'h7FFF_8000, 1'b0);
        queue_word(32'h0000_FFFF, 1'b0);
        // six triangle vertices plus three markers from one word
        queue_word({CMD_END, CMD_END, CMD_END, CMD_VTX_YZ}, 1'b0);
        queue_word(32'h1234_5678, 1'b0);
        // partial group dropped at end of primitive, wrapping deltas
        queue_word({CMD_BEGIN, CMD_END, CMD_VTX_DIFF, CMD_VTX_DIFF}, 1'b0);
        queue_word(32'h1FFF_FDFF, 1'b0);
        queue_word(32'h2008_0200, 1'b0);
        queue_word(32'h0000_0002, 1'b0);      // tri strip
        // quad strip and the two ignored commands
        queue_word({CMD_SKIP1, CMD_SKIP3, CMD_VTX_XY, CMD_BEGIN}, 1'b0);
        queue_word(32'h0000_0003, 1'b0);
        queue_word(32'h0001_0001, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b0);
        queue_word(32'h0000_0000, 1'b0);
        queue_word(32'h5555_AAAA, 1'b0);
        queue_word(32'hAAAA_5555, 1'b0);
        // mesh restart while a vtx16 still waits for its second word
        drain_next = 1'b1;
        queue_word({CMD_END, 8'h00, 8'h00, CMD_VTX16}, 1'b0);
        queue_word(32'hAAAA_5555, 1'b0);
        queue_word({CMD_END, CMD_END, CMD_END, CMD_END}, 1'b1);
        directed = word_q.size();

        // random meshes with some noise between them
        while (word_q.size() < directed + 500)
        begin
            if (word_q.size() >= directed + 250 && word_q.size() < directed + 260)
                drain_next = 1'b1;
            if ($urandom_range(0, 11) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    queue_word($urandom, 1'($urandom_range(0, 5) == 0));
                in_sync = 1'b0;
            end
            else
            begin
                add_mesh();
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (word_q.size() != 0 || pending_results.size() != 0)
            @(posedge clk);
        // let any stray result show up
        repeat (20) @(posedge clk);

        $display("covered %0d stream words: %0d vertices and %0d end markers checked",
                 words_taken, vertices_seen, markers_seen);
        $display("%0d complete quad groups split into triangles", quads_done);
        if (mismatches == 0)
            $display("geometry_command_vertex_decoder_tb OK");
        else
            $display("geometry_command_vertex_decoder_tb NOT OK");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("timeout: results still missing");
        $display("geometry_command_vertex_decoder_tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/gcvd_pkg.sv
design/geometry_command_vertex_decoder.sv
test/geometry_command_vertex_decoder_tb.sv
